// ----- rtl/core/bpc_pkg.sv -----
// Shared types and constants for the barometric pressure compensation pipeline.
`timescale 1ns / 1ps

package bpc_pkg;

    // Pipeline depth, in register stages.
    localparam int NSTG = 10;

    // Widths of the ports.
    localparam int RAW_W  = 24;
    localparam int COEF_W = 16;
    localparam int IDX_W  = 3;
    localparam int TEMP_W = 15;
    localparam int PRES_W = 17;

    // Reference temperature and saturation bounds.
    localparam int TEMP_REF_CENTI = 2000;
    localparam int TEMP_MIN_CENTI = -4000;
    localparam int TEMP_MAX_CENTI = 8500;
    localparam int PRES_MIN_PA    = 1000;
    localparam int PRES_MAX_PA    = 120000;

    // Configuration register indexes.
    typedef enum logic [IDX_W-1:0] {
        CFG_PRES_SENS = 3'd0,
        CFG_PRES_OFF  = 3'd1,
        CFG_SENS_TC   = 3'd2,
        CFG_OFF_TC    = 3'd3,
        CFG_TEMP_REF  = 3'd4,
        CFG_TEMP_TC   = 3'd5
    } t_cfg_idx;

    // Factory calibration words.
    typedef struct packed {
        logic [COEF_W-1:0] pres_sens;
        logic [COEF_W-1:0] pres_off;
        logic [COEF_W-1:0] sens_tc;
        logic [COEF_W-1:0] off_tc;
        logic [COEF_W-1:0] temp_ref;
        logic [COEF_W-1:0] temp_tc;
    } t_coefs;

    // First-order terms, leaving the front section.
    typedef struct packed {
        logic [RAW_W-1:0]  d1;
        logic signed [17:0] d;
        logic signed [18:0] temp1;
        logic               low;
        logic [17:0]        t2;
        logic signed [34:0] off1;
        logic signed [33:0] sens1;
    } t_first;

    // Corrected terms, leaving the second-order section.
    typedef struct packed {
        logic [RAW_W-1:0]   d1;
        logic signed [38:0] off;
        logic signed [37:0] sens;
        logic [TEMP_W-1:0]  temp;
        logic               thit;
    } t_mid;

endpackage

// ----- rtl/core/bpc_first.sv -----
// Front stages: temperature difference, the four products and the first-order terms.
`timescale 1ns / 1ps

module bpc_first (
    input  logic                       i_clk,
    input  logic [2:0]                 i_adv,
    input  bpc_pkg::t_coefs            i_coefs,
    input  logic [bpc_pkg::RAW_W-1:0]  i_raw_pressure,
    input  logic [bpc_pkg::RAW_W-1:0]  i_raw_temperature,
    output bpc_pkg::t_first            o_first
);
    import bpc_pkg::*;

    // Stage one registers.
    logic [RAW_W-1:0]   r_d1_s1;
    logic signed [24:0] r_dt;
    // Stage two registers.
    logic [RAW_W-1:0]   r_d1_s2;
    logic signed [40:0] r_p6;
    logic signed [40:0] r_p4;
    logic signed [40:0] r_p3;
    logic [17:0]        r_t2;
    // Stage three register.
    t_first             r_out;

    logic signed [24:0] n_dt;
    logic signed [40:0] w_p6;
    logic signed [40:0] w_p4;
    logic signed [40:0] w_p3;
    logic signed [49:0] w_pdd;
    logic signed [40:0] w_b6;
    logic signed [40:0] w_b4;
    logic signed [40:0] w_b3;
    logic signed [17:0] w_q6;
    logic signed [33:0] w_q4;
    logic signed [32:0] w_q3;
    t_first             n_out;

    // Difference between the raw temperature and the reference reading.
    assign n_dt = $signed({1'b0, i_raw_temperature})
                - $signed({1'b0, i_coefs.temp_ref, 8'b0});

    // Products of the difference with the slope words and with itself.
    assign w_p6  = r_dt * $signed({1'b0, i_coefs.temp_tc});
    assign w_p4  = r_dt * $signed({1'b0, i_coefs.off_tc});
    assign w_p3  = r_dt * $signed({1'b0, i_coefs.sens_tc});
    assign w_pdd = r_dt * r_dt;

    // Shifts that round toward zero: negative values get a bias first.
    assign w_b6 = r_p6 + (r_p6[40] ? 41'sd8388607 : 41'sd0);
    assign w_b4 = r_p4 + (r_p4[40] ? 41'sd127 : 41'sd0);
    assign w_b3 = r_p3 + (r_p3[40] ? 41'sd255 : 41'sd0);
    assign w_q6 = w_b6[40:23];
    assign w_q4 = w_b4[40:7];
    assign w_q3 = w_b3[40:8];

    // First-order temperature, offset and sensitivity.
    always_comb begin
        n_out.d1    = r_d1_s2;
        n_out.d     = w_q6;
        n_out.temp1 = {w_q6[17], w_q6} + 19'(TEMP_REF_CENTI);
        n_out.low   = w_q6[17];
        n_out.t2    = r_t2;
        n_out.off1  = $signed({3'b0, i_coefs.pres_off, 16'b0}) + {w_q4[33], w_q4};
        n_out.sens1 = $signed({3'b0, i_coefs.pres_sens, 15'b0}) + {w_q3[32], w_q3};
    end

    always_ff @(posedge i_clk) begin
        if (i_adv[0]) begin
            r_d1_s1 <= i_raw_pressure;
            r_dt    <= n_dt;
        end
        if (i_adv[1]) begin
            r_d1_s2 <= r_d1_s1;
            r_p6    <= w_p6;
            r_p4    <= w_p4;
            r_p3    <= w_p3;
            r_t2    <= w_pdd[48:31];
        end
        if (i_adv[2]) begin
            r_out <= n_out;
        end
    end

    assign o_first = r_out;

endmodule

// ----- rtl/core/bpc_second.sv -----
// Second-order correction stages and temperature saturation.
`timescale 1ns / 1ps

module bpc_second (
    input  logic            i_clk,
    input  logic [1:0]      i_adv,
    input  bpc_pkg::t_first i_first,
    output bpc_pkg::t_mid   o_mid
);
    import bpc_pkg::*;

    // Stage four registers.
    logic [RAW_W-1:0]   r_d1;
    logic [34:0]        r_dsq;
    logic signed [19:0] r_temp2;
    logic signed [34:0] r_off1;
    logic signed [33:0] r_sens1;
    // Stage five register.
    t_mid               r_out;

    logic signed [35:0] w_sq;
    logic signed [19:0] n_temp2;
    logic [37:0]        w_f5;
    t_mid               n_out;

    // Square of the temperature deviation, only used below the reference.
    assign w_sq = i_first.d * i_first.d;
    assign n_temp2 = {i_first.temp1[18], i_first.temp1}
                   - $signed({2'b0, (i_first.low ? i_first.t2 : 18'd0)});

    // Five times the square, then the offset and sensitivity corrections.
    assign w_f5 = {1'b0, r_dsq, 2'b00} + {3'b000, r_dsq};

    always_comb begin
        n_out.d1   = r_d1;
        n_out.off  = {{4{r_off1[34]}}, r_off1} - $signed({2'b0, w_f5[37:1]});
        n_out.sens = {{4{r_sens1[33]}}, r_sens1} - $signed({2'b0, w_f5[37:2]});
        if (r_temp2 < 20'(TEMP_MIN_CENTI)) begin
            n_out.temp = TEMP_W'(TEMP_MIN_CENTI);
            n_out.thit = 1'b1;
        end else if (r_temp2 > 20'(TEMP_MAX_CENTI)) begin
            n_out.temp = TEMP_W'(TEMP_MAX_CENTI);
            n_out.thit = 1'b1;
        end else begin
            n_out.temp = r_temp2[TEMP_W-1:0];
            n_out.thit = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv[0]) begin
            r_d1    <= i_first.d1;
            r_dsq   <= i_first.low ? w_sq[34:0] : 35'd0;
            r_temp2 <= n_temp2;
            r_off1  <= i_first.off1;
            r_sens1 <= i_first.sens1;
        end
        if (i_adv[1]) begin
            r_out <= n_out;
        end
    end

    assign o_mid = r_out;

endmodule

// ----- rtl/core/bpc_pres.sv -----
// Pressure stages: split product, scaling, offset removal and pressure saturation.
`timescale 1ns / 1ps

module bpc_pres (
    input  logic                        i_clk,
    input  logic [4:0]                  i_adv,
    input  bpc_pkg::t_mid               i_mid,
    output logic [bpc_pkg::TEMP_W-1:0]  o_temp,
    output logic [bpc_pkg::PRES_W-1:0]  o_pres,
    output logic                        o_hit
);
    import bpc_pkg::*;

    // Temperature result and its flag ride along with the pressure stages.
    logic [TEMP_W-1:0]  r_temp [4:0];
    logic               r_thit [3:0];
    logic signed [38:0] r_off  [2:0];

    logic [43:0]        r_pl;
    logic signed [41:0] r_ph;
    logic signed [61:0] r_prod;
    logic signed [40:0] r_q;
    logic signed [41:0] r_x;
    logic [PRES_W-1:0]  r_pres;
    logic               r_hit;

    logic [43:0]        w_pl;
    logic signed [41:0] w_ph;
    logic signed [61:0] w_prod;
    logic signed [61:0] w_b8;
    logic signed [41:0] w_x;
    logic signed [41:0] w_b10;
    logic signed [26:0] w_p;
    logic [PRES_W-1:0]  n_pres;
    logic               n_phit;

    // Raw pressure times sensitivity, as low and high partial products.
    assign w_pl = i_mid.d1 * i_mid.sens[19:0];
    assign w_ph = $signed({1'b0, i_mid.d1}) * $signed(i_mid.sens[37:20]);

    // Recombine the partial products.
    assign w_prod = $signed({r_ph, 20'b0}) + $signed({18'b0, r_pl});

    // Scale down, rounding toward zero.
    assign w_b8 = r_prod + (r_prod[61] ? 62'sd2097151 : 62'sd0);

    // Remove the offset.
    assign w_x = {r_q[40], r_q} - {{3{r_off[2][38]}}, r_off[2]};

    // Final scaling and saturation.
    assign w_b10 = r_x + (r_x[41] ? 42'sd32767 : 42'sd0);
    assign w_p   = w_b10[41:15];

    always_comb begin
        if (w_p < 27'(PRES_MIN_PA)) begin
            n_pres = PRES_W'(PRES_MIN_PA);
            n_phit = 1'b1;
        end else if (w_p > 27'(PRES_MAX_PA)) begin
            n_pres = PRES_W'(PRES_MAX_PA);
            n_phit = 1'b1;
        end else begin
            n_pres = w_p[PRES_W-1:0];
            n_phit = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv[0]) begin
            r_pl      <= w_pl;
            r_ph      <= w_ph;
            r_off[0]  <= i_mid.off;
            r_temp[0] <= i_mid.temp;
            r_thit[0] <= i_mid.thit;
        end
        if (i_adv[1]) begin
            r_prod    <= w_prod;
            r_off[1]  <= r_off[0];
            r_temp[1] <= r_temp[0];
            r_thit[1] <= r_thit[0];
        end
        if (i_adv[2]) begin
            r_q       <= w_b8[61:21];
            r_off[2]  <= r_off[1];
            r_temp[2] <= r_temp[1];
            r_thit[2] <= r_thit[1];
        end
        if (i_adv[3]) begin
            r_x       <= w_x;
            r_temp[3] <= r_temp[2];
            r_thit[3] <= r_thit[2];
        end
        if (i_adv[4]) begin
            r_pres    <= n_pres;
            r_hit     <= n_phit | r_thit[3];
            r_temp[4] <= r_temp[3];
        end
    end

    assign o_temp = r_temp[4];
    assign o_pres = r_pres;
    assign o_hit  = r_hit;

endmodule

// ----- rtl/core/barometric_pressure_compensation_unit.sv -----
// Top level of the barometric pressure compensation pipeline.
`timescale 1ns / 1ps

// The unit accepts one pair of raw pressure and temperature conversions per
// clock while o_ready is high and returns the temperature in hundredths of a
// degree and the pressure in pascals, both saturated to the sensor range, with
// a flag when either was saturated. Throughput is one transfer per cycle unless
// the output stalls; the arithmetic has ten register stages (products, rounding
// shifts, second-order correction, the split 24 by 38 bit pressure product and
// the final scaling). Stages hold their data when the output is stalled and
// empty stages still take new input, so a stall loses nothing. The six
// calibration words are written through the plain write port, indexes six and
// seven are ignored, and they must only change while the pipeline is empty.
module barometric_pressure_compensation_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [bpc_pkg::IDX_W-1:0]   i_cfg_idx,
    input  logic [bpc_pkg::COEF_W-1:0]  i_cfg_data,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [bpc_pkg::RAW_W-1:0]   i_raw_pressure,
    input  logic [bpc_pkg::RAW_W-1:0]   i_raw_temperature,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [bpc_pkg::TEMP_W-1:0]  o_temperature_centi,
    output logic [bpc_pkg::PRES_W-1:0]  o_pressure_pa,
    output logic                        o_clamped
);
    import bpc_pkg::*;

    t_coefs            r_coefs;
    logic [NSTG-1:0]   r_vld;
    logic [NSTG-1:0]   w_rdy;
    t_first            w_first;
    t_mid              w_mid;

    // Calibration register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coefs <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PRES_SENS: r_coefs.pres_sens <= i_cfg_data;
                CFG_PRES_OFF:  r_coefs.pres_off  <= i_cfg_data;
                CFG_SENS_TC:   r_coefs.sens_tc   <= i_cfg_data;
                CFG_OFF_TC:    r_coefs.off_tc    <= i_cfg_data;
                CFG_TEMP_REF:  r_coefs.temp_ref  <= i_cfg_data;
                CFG_TEMP_TC:   r_coefs.temp_tc   <= i_cfg_data;
                default:       r_coefs <= r_coefs;
            endcase
        end
    end

    // A stage can load when it is empty or its content moves on.
    always_comb begin
        w_rdy[NSTG-1] = !r_vld[NSTG-1] || i_ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
    end

    // Valid bits travel with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (w_rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_ready = w_rdy[0];
    assign o_valid = r_vld[NSTG-1];

    bpc_first u_first (
        .i_clk             (i_clk),
        .i_adv             (w_rdy[2:0]),
        .i_coefs           (r_coefs),
        .i_raw_pressure    (i_raw_pressure),
        .i_raw_temperature (i_raw_temperature),
        .o_first           (w_first)
    );

    bpc_second u_second (
        .i_clk   (i_clk),
        .i_adv   (w_rdy[4:3]),
        .i_first (w_first),
        .o_mid   (w_mid)
    );

    bpc_pres u_pres (
        .i_clk  (i_clk),
        .i_adv  (w_rdy[9:5]),
        .i_mid  (w_mid),
        .o_temp (o_temperature_centi),
        .o_pres (o_pressure_pa),
        .o_hit  (o_clamped)
    );

    // Results always lie inside the sensor range.
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($signed(o_temperature_centi) >= -15'sd4000 &&
                     $signed(o_temperature_centi) <= 15'sd8500 &&
                     o_pressure_pa >= 17'd1000 && o_pressure_pa <= 17'd120000))
        else $error("result outside sensor range");

    // A saturated result sits on one of the bounds.
    a_clamp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_clamped) |->
            ($signed(o_temperature_centi) == -15'sd4000 ||
             $signed(o_temperature_centi) == 15'sd8500 ||
             o_pressure_pa == 17'd1000 || o_pressure_pa == 17'd120000))
        else $error("saturation flag without a bound value");

    // Input is refused only when every stage is occupied.
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (&r_vld))
        else $error("input refused while a stage is empty");

    // Reset empties the pipeline.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule
